>>> hdl/inv3_pkg.sv
// ============================================================================
// inv3_pkg
// Shared constants, index tables and flag type for the 3x3 inverse pipeline.
// ============================================================================
package inv3_pkg;

    // elements in one matrix item
    localparam int NUM_ELEM = 9;
    localparam int IDX_W    = 4;

    typedef logic [IDX_W-1:0] t_idx;

    // adjugate element i (a signed cofactor) = m[A]*m[B] - m[C]*m[D], element order row-major
    localparam t_idx COF_A [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_idx COF_B [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_idx COF_C [NUM_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_idx COF_D [NUM_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // cofactors used by the first-row expansion of the determinant
    localparam t_idx DET_COF [3] = '{4'd0, 4'd3, 4'd6};

    // status of one result item
    typedef struct packed {
        logic singular;
        logic overflow;
    } t_flags;

endpackage

>>> hdl/inv3_cofactor.sv
// ============================================================================
// inv3_cofactor
// Two-stage cofactor unit: eighteen element products, then nine exact
// product differences. Row 0 is delayed alongside for the determinant.
// ============================================================================
module inv3_cofactor
    import inv3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [ELEM_WIDTH-1:0] i_m   [NUM_ELEM],
    output logic                         o_valid,
    output logic signed [2*ELEM_WIDTH:0] o_cof [NUM_ELEM],
    output logic signed [ELEM_WIDTH-1:0] o_row [3]
);

    localparam int PW = 2 * ELEM_WIDTH;

    logic                  r_vld_a, r_vld_b;
    logic signed [PW-1:0]  r_pa [NUM_ELEM];
    logic signed [PW-1:0]  r_pb [NUM_ELEM];
    logic signed [PW:0]    r_cof [NUM_ELEM];
    logic signed [ELEM_WIDTH-1:0] r_row_a [3];
    logic signed [ELEM_WIDTH-1:0] r_row_b [3];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    // stage 1: products; stage 2: differences
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_ELEM; i++) begin
            r_pa[i]  <= i_m[COF_A[i]] * i_m[COF_B[i]];
            r_pb[i]  <= i_m[COF_C[i]] * i_m[COF_D[i]];
            r_cof[i] <= $signed({r_pa[i][PW-1], r_pa[i]}) - $signed({r_pb[i][PW-1], r_pb[i]});
        end
        for (int j = 0; j < 3; j++) begin
            r_row_a[j] <= i_m[j];
            r_row_b[j] <= r_row_a[j];
        end
    end

    assign o_valid = r_vld_b;
    assign o_cof   = r_cof;
    assign o_row   = r_row_b;

endmodule

>>> hdl/inv3_det.sv
// ============================================================================
// inv3_det
// Three-stage determinant: split partial products of row 0 by its
// cofactors, recombine, then sum. Cofactors travel along.
// ============================================================================
module inv3_det
    import inv3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [2*ELEM_WIDTH:0]     i_cof [NUM_ELEM],
    input  logic signed [ELEM_WIDTH-1:0]     i_row [3],
    output logic                             o_valid,
    output logic signed [3*ELEM_WIDTH+1:0]   o_det,
    output logic signed [2*ELEM_WIDTH:0]     o_cof [NUM_ELEM]
);

    localparam int W    = ELEM_WIDTH;
    localparam int CW   = 2 * W + 1;
    localparam int PW   = 3 * W + 1;
    localparam int DETW = 3 * W + 2;

    logic [2:0]              r_vld;
    logic signed [2*W:0]     r_hi [3];
    logic signed [2*W:0]     r_lo [3];
    logic signed [PW-1:0]    r_prod [3];
    logic signed [DETW-1:0]  r_det;
    logic signed [CW-1:0]    r_cof_a [NUM_ELEM];
    logic signed [CW-1:0]    r_cof_b [NUM_ELEM];
    logic signed [CW-1:0]    r_cof_c [NUM_ELEM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // cofactor split: signed high part, unsigned low W bits
        for (int j = 0; j < 3; j++) begin
            r_hi[j]   <= i_row[j] * $signed(i_cof[DET_COF[j]][CW-1:W]);
            r_lo[j]   <= i_row[j] * $signed({1'b0, i_cof[DET_COF[j]][W-1:0]});
            r_prod[j] <= (PW'(r_hi[j]) <<< W) + PW'(r_lo[j]);
        end
        r_det <= DETW'(r_prod[0]) + DETW'(r_prod[1]) + DETW'(r_prod[2]);
        r_cof_a <= i_cof;
        r_cof_b <= r_cof_a;
        r_cof_c <= r_cof_b;
    end

    assign o_valid = r_vld[2];
    assign o_det   = r_det;
    assign o_cof   = r_cof_c;

endmodule

>>> hdl/inv3_divider.sv
// ============================================================================
// inv3_divider
// Nine-lane pipelined divider: magnitudes, range check, one quotient bit
// per stage, then round to nearest, saturate and apply sign.
// ============================================================================
module inv3_divider
    import inv3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [3*ELEM_WIDTH+1:0]  i_det,
    input  logic signed [2*ELEM_WIDTH:0]    i_cof [NUM_ELEM],
    output logic                            o_valid,
    output logic [ELEM_WIDTH-1:0]           o_q   [NUM_ELEM],
    output t_flags                          o_flags
);

    localparam int W     = ELEM_WIDTH;
    localparam int CW    = 2 * W + 1;
    localparam int CMW   = 2 * W;
    localparam int DETW  = 3 * W + 2;
    localparam int DMW   = 3 * W + 1;
    localparam int SH    = 2 * FRAC_BITS + 1;
    localparam int NW    = CMW + SH;
    localparam int TW    = NW - (W + 1);
    localparam int CMPW  = (TW > DMW) ? TW : DMW;
    localparam int STEPS = W + 1;

    // magnitude stage
    logic                 r_vld_m;
    logic [DMW-1:0]       r_dmag_m;
    logic                 r_dzero_m;
    logic [CMW-1:0]       r_cmag_m [NUM_ELEM];
    logic                 r_neg_m  [NUM_ELEM];

    // divide pipeline, index 0 is the range-check stage
    logic                 r_vld   [0:STEPS];
    logic [DMW-1:0]       r_dmag  [0:STEPS];
    logic                 r_dzero [0:STEPS];
    logic [DMW-1:0]       r_rem   [0:STEPS][NUM_ELEM];
    logic [W:0]           r_low   [0:STEPS][NUM_ELEM];
    logic [W:0]           r_quo   [0:STEPS][NUM_ELEM];
    logic                 r_big   [0:STEPS][NUM_ELEM];
    logic                 r_neg   [0:STEPS][NUM_ELEM];

    // output stage
    logic                 r_vld_o;
    logic [W-1:0]         r_q     [NUM_ELEM];
    t_flags               r_flags;

    logic signed [DETW-1:0] n_dabs;
    logic signed [CW-1:0]   n_cabs [NUM_ELEM];
    logic [NW-1:0]          n_num  [NUM_ELEM];
    logic [CMPW-1:0]        n_top  [NUM_ELEM];
    logic [W:0]             n_rnd  [NUM_ELEM];
    logic [W:0]             n_lim  [NUM_ELEM];
    logic [W:0]             n_val  [NUM_ELEM];
    logic                   n_sat  [NUM_ELEM];
    logic                   n_ngo  [NUM_ELEM];
    logic [W-1:0]           n_q    [NUM_ELEM];
    logic                   n_ovf;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= 1'b0;
            r_vld_o <= 1'b0;
            for (int s = 0; s <= STEPS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld_m  <= i_valid;
            r_vld[0] <= r_vld_m;
            for (int s = 0; s < STEPS; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
            r_vld_o <= r_vld[STEPS];
        end
    end

    // magnitudes and signs
    always_comb begin
        n_dabs = i_det[DETW-1] ? -i_det : i_det;
        for (int l = 0; l < NUM_ELEM; l++) begin
            n_cabs[l] = i_cof[l][CW-1] ? -i_cof[l] : i_cof[l];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dmag_m  <= n_dabs[DMW-1:0];
        r_dzero_m <= (i_det == '0);
        for (int l = 0; l < NUM_ELEM; l++) begin
            r_cmag_m[l] <= n_cabs[l][CMW-1:0];
            r_neg_m[l]  <= i_cof[l][CW-1] != i_det[DETW-1];
        end
    end

    // range check: quotient must fit W+1 bits before rounding
    always_comb begin
        for (int l = 0; l < NUM_ELEM; l++) begin
            n_num[l] = {r_cmag_m[l], {SH{1'b0}}};
            n_top[l] = CMPW'(n_num[l][NW-1:W+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dmag[0]  <= r_dmag_m;
        r_dzero[0] <= r_dzero_m;
        for (int l = 0; l < NUM_ELEM; l++) begin
            r_big[0][l] <= n_top[l] >= CMPW'(r_dmag_m);
            r_rem[0][l] <= n_top[l][DMW-1:0];
            r_low[0][l] <= n_num[l][W:0];
            r_quo[0][l] <= '0;
            r_neg[0][l] <= r_neg_m[l];
        end
    end

    // restoring division, one bit per stage
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [DMW:0] n_shift [NUM_ELEM];
        logic [DMW:0] n_diff  [NUM_ELEM];

        always_comb begin
            for (int l = 0; l < NUM_ELEM; l++) begin
                n_shift[l] = {r_rem[s][l], r_low[s][l][W]};
                n_diff[l]  = n_shift[l] - {1'b0, r_dmag[s]};
            end
        end

        always_ff @(posedge i_clk) begin
            r_dmag[s+1]  <= r_dmag[s];
            r_dzero[s+1] <= r_dzero[s];
            for (int l = 0; l < NUM_ELEM; l++) begin
                r_rem[s+1][l] <= n_diff[l][DMW] ? n_shift[l][DMW-1:0] : n_diff[l][DMW-1:0];
                r_quo[s+1][l] <= {r_quo[s][l][W-1:0], ~n_diff[l][DMW]};
                r_low[s+1][l] <= {r_low[s][l][W-1:0], 1'b0};
                r_big[s+1][l] <= r_big[s][l];
                r_neg[s+1][l] <= r_neg[s][l];
            end
        end
    end

    // round half away from zero, saturate, sign; all-zero on a zero determinant
    always_comb begin
        n_ovf = 1'b0;
        for (int l = 0; l < NUM_ELEM; l++) begin
            n_rnd[l] = (W+1)'(({1'b0, r_quo[STEPS][l]} + (W+2)'(1)) >> 1);
            n_ngo[l] = r_neg[STEPS][l] && (r_big[STEPS][l] || (n_rnd[l] != '0));
            n_lim[l] = ((W+1)'(1) << (W-1)) - (W+1)'(!n_ngo[l]);
            n_sat[l] = r_big[STEPS][l] || (n_rnd[l] > n_lim[l]);
            n_val[l] = n_sat[l] ? n_lim[l] : n_rnd[l];
            n_q[l]   = n_ngo[l] ? -n_val[l][W-1:0] : n_val[l][W-1:0];
            if (r_dzero[STEPS]) begin
                n_q[l] = '0;
            end
            n_ovf = n_ovf | n_sat[l];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q              <= n_q;
        r_flags.singular <= r_dzero[STEPS];
        r_flags.overflow <= n_ovf && !r_dzero[STEPS];
    end

    assign o_valid = r_vld_o;
    assign o_q     = r_q;
    assign o_flags = r_flags;

endmodule

>>> hdl/inverse_3x3_matrix.sv
// ============================================================================
// inverse_3x3_matrix
// Pipelined 3x3 inverse of signed fixed-point matrices by adjugate over
// determinant, rounded and saturated.
// ============================================================================
// One matrix is taken in every clock cycle; o_busy is always low. Each item's
// result appears on o_done after the cofactor products and differences, the
// determinant's split products, recombination and sum, the magnitude and
// range-check stages, the divider that retires one quotient bit per stage,
// and the round-and-saturate stage. Results are shown for one cycle and
// cannot be held off. A zero determinant gives all-zero elements with
// o_singular set; a saturated element of a nonsingular matrix sets
// o_overflow.
module inverse_3x3_matrix
    import inv3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [ELEM_WIDTH-1:0] i_m00,
    input  logic signed [ELEM_WIDTH-1:0] i_m01,
    input  logic signed [ELEM_WIDTH-1:0] i_m02,
    input  logic signed [ELEM_WIDTH-1:0] i_m10,
    input  logic signed [ELEM_WIDTH-1:0] i_m11,
    input  logic signed [ELEM_WIDTH-1:0] i_m12,
    input  logic signed [ELEM_WIDTH-1:0] i_m20,
    input  logic signed [ELEM_WIDTH-1:0] i_m21,
    input  logic signed [ELEM_WIDTH-1:0] i_m22,
    output logic                         o_done,
    output logic signed [ELEM_WIDTH-1:0] o_m00,
    output logic signed [ELEM_WIDTH-1:0] o_m01,
    output logic signed [ELEM_WIDTH-1:0] o_m02,
    output logic signed [ELEM_WIDTH-1:0] o_m10,
    output logic signed [ELEM_WIDTH-1:0] o_m11,
    output logic signed [ELEM_WIDTH-1:0] o_m12,
    output logic signed [ELEM_WIDTH-1:0] o_m20,
    output logic signed [ELEM_WIDTH-1:0] o_m21,
    output logic signed [ELEM_WIDTH-1:0] o_m22,
    output logic                         o_singular,
    output logic                         o_overflow
);

    localparam int W   = ELEM_WIDTH;
    localparam int LAT = ELEM_WIDTH + 9;

    logic signed [W-1:0]     n_m [NUM_ELEM];
    logic                    n_take;
    logic                    cof_vld;
    logic signed [2*W:0]     cof_val [NUM_ELEM];
    logic signed [W-1:0]     cof_row [3];
    logic                    det_vld;
    logic signed [3*W+1:0]   det_val;
    logic signed [2*W:0]     det_cof [NUM_ELEM];
    logic                    div_vld;
    logic [W-1:0]            div_q [NUM_ELEM];
    t_flags                  div_flags;

    // no back-pressure: an item is taken whenever start is high
    assign o_busy = 1'b0;
    assign n_take = i_start && !o_busy;

    assign n_m = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};

    inv3_cofactor #(.ELEM_WIDTH(ELEM_WIDTH)) u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_take),
        .i_m     (n_m),
        .o_valid (cof_vld),
        .o_cof   (cof_val),
        .o_row   (cof_row)
    );

    inv3_det #(.ELEM_WIDTH(ELEM_WIDTH)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cof_vld),
        .i_cof   (cof_val),
        .i_row   (cof_row),
        .o_valid (det_vld),
        .o_det   (det_val),
        .o_cof   (det_cof)
    );

    inv3_divider #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (det_vld),
        .i_det   (det_val),
        .i_cof   (det_cof),
        .o_valid (div_vld),
        .o_q     (div_q),
        .o_flags (div_flags)
    );

    // result ports
    assign o_done     = div_vld;
    assign o_m00      = $signed(div_q[0]);
    assign o_m01      = $signed(div_q[1]);
    assign o_m02      = $signed(div_q[2]);
    assign o_m10      = $signed(div_q[3]);
    assign o_m11      = $signed(div_q[4]);
    assign o_m12      = $signed(div_q[5]);
    assign o_m20      = $signed(div_q[6]);
    assign o_m21      = $signed(div_q[7]);
    assign o_m22      = $signed(div_q[8]);
    assign o_singular = div_flags.singular;
    assign o_overflow = div_flags.overflow;

    // every result traces back to an item taken out of reset
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && i_rst_n, LAT))
        else $error("result without a matching item");

    // singular results carry no overflow
    a_sing_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_singular) |-> !o_overflow)
        else $error("overflow on singular matrix");

    // singular results are all zero
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_singular) |-> ((o_m00 == '0) && (o_m01 == '0) && (o_m02 == '0)
            && (o_m10 == '0) && (o_m11 == '0) && (o_m12 == '0)
            && (o_m20 == '0) && (o_m21 == '0) && (o_m22 == '0)))
        else $error("nonzero element on singular matrix");

endmodule
